// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker module of the risk monitor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define TRM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, switched off while reset is high.
`define TRM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

// Check of what reset leaves behind; it stays active during reset.
`define TRM_ASSERT_RESET(lbl, clk, rst, cons) \
   lbl: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("reset check failed");

`endif

// ----- hdl/trm_pkg.sv -----
// Package with the types, codes and constants of the telemetry risk monitor.
package trm_pkg;

   // Widths.
   localparam int COUNT_BITS_DEFAULT = 32;
   localparam int SUM_BITS           = 64;
   localparam int REPORT_BITS        = 32;
   localparam int POS_BITS           = 24;
   localparam int BATTERY_BITS       = 15;
   localparam int SIGNAL_BITS        = 9;
   localparam int SCORE_BITS         = 7;
   localparam int LEVEL_BITS         = 3;
   localparam int FLAG_BITS          = 4;
   localparam int CSR_INDEX_BITS     = 3;
   localparam int CSR_DATA_BITS      = 24;
   localparam int QUEUE_DEPTH        = 4;

   // Function codes of an input item.
   typedef enum logic [1:0] {
      FUNC_SAMPLE = 2'd0,
      FUNC_REPORT = 2'd1,
      FUNC_CLEAR  = 2'd2,
      FUNC_UNUSED = 2'd3
   } trm_func_type;

   // Register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BATTERY_CRITICAL  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BATTERY_CAUTION   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SIGNAL_CRITICAL   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SIGNAL_CAUTION    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ALTITUDE_CRITICAL = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ALTITUDE_CAUTION  = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPEED_CRITICAL    = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPEED_CAUTION     = 3'd7;

   // Register reset values.
   localparam logic [BATTERY_BITS-1:0]    BATTERY_CRITICAL_RESET  = 15'd6400;
   localparam logic [BATTERY_BITS-1:0]    BATTERY_CAUTION_RESET   = 15'd10240;
   localparam logic signed [SIGNAL_BITS-1:0] SIGNAL_CRITICAL_RESET = -9'sd85;
   localparam logic signed [SIGNAL_BITS-1:0] SIGNAL_CAUTION_RESET  = -9'sd75;
   localparam logic signed [POS_BITS-1:0] ALTITUDE_CRITICAL_RESET = 24'sd256000;
   localparam logic signed [POS_BITS-1:0] ALTITUDE_CAUTION_RESET  = 24'sd204800;
   localparam logic signed [POS_BITS-1:0] SPEED_CRITICAL_RESET    = 24'sd20480;
   localparam logic signed [POS_BITS-1:0] SPEED_CAUTION_RESET     = 24'sd15360;

   // Score weights and limits.
   localparam logic [SCORE_BITS-1:0] WEIGHT_BATTERY_CRITICAL = 7'd35;
   localparam logic [SCORE_BITS-1:0] WEIGHT_BATTERY_CAUTION  = 7'd15;
   localparam logic [SCORE_BITS-1:0] WEIGHT_SIGNAL_CRITICAL  = 7'd30;
   localparam logic [SCORE_BITS-1:0] WEIGHT_SIGNAL_CAUTION   = 7'd10;
   localparam logic [SCORE_BITS-1:0] WEIGHT_POS_CRITICAL     = 7'd25;
   localparam logic [SCORE_BITS-1:0] WEIGHT_POS_CAUTION      = 7'd10;
   localparam logic [SCORE_BITS-1:0] SCORE_MAX               = 7'd100;
   localparam logic [SCORE_BITS-1:0] SCORE_CRITICAL          = 7'd80;
   localparam logic [SCORE_BITS-1:0] SCORE_HIGH              = 7'd60;
   localparam logic [SCORE_BITS-1:0] SCORE_WARNING           = 7'd40;
   localparam logic [SCORE_BITS-1:0] SCORE_NONE              = 7'd0;

   // Risk level codes.
   localparam logic [LEVEL_BITS-1:0] LEVEL_NORMAL   = 3'd0;
   localparam logic [LEVEL_BITS-1:0] LEVEL_LOW      = 3'd1;
   localparam logic [LEVEL_BITS-1:0] LEVEL_MEDIUM   = 3'd2;
   localparam logic [LEVEL_BITS-1:0] LEVEL_HIGH     = 3'd3;
   localparam logic [LEVEL_BITS-1:0] LEVEL_CRITICAL = 3'd4;

   // Battery floor after reset or clear: one hundred percent.
   localparam logic [BATTERY_BITS-1:0] BATTERY_FULL = 15'd25600;

   // A classified item as it waits between the front and the back.
   typedef struct packed {
      trm_func_type                 func;
      logic signed [POS_BITS-1:0]   altitude;
      logic signed [POS_BITS-1:0]   velocity;
      logic [BATTERY_BITS-1:0]      battery;
      logic [SCORE_BITS-1:0]        risk_score;
      logic [LEVEL_BITS-1:0]        risk_level;
      logic                         warning;
      logic [FLAG_BITS-1:0]         alarm_flags;
   } trm_item_type;

   // States of the back end.
   typedef enum logic {
      BACK_RUN,
      BACK_DIVIDE
   } trm_back_state_type;

endpackage

// ----- hdl/trm_front.sv -----
// Front end: threshold registers and scoring of each incoming item.
module trm_front import trm_pkg::*; (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write,
   input  logic [CSR_INDEX_BITS-1:0]        csr_index,
   input  logic [CSR_DATA_BITS-1:0]         csr_wdata,
   input  logic [1:0]                       req_func,
   input  logic signed [POS_BITS-1:0]       req_altitude,
   input  logic signed [POS_BITS-1:0]       req_velocity,
   input  logic [BATTERY_BITS-1:0]          req_battery,
   input  logic signed [SIGNAL_BITS-1:0]    req_signal_dbm,
   output trm_item_type                     item
);

   logic [BATTERY_BITS-1:0]       battery_critical_ff, battery_critical_in;
   logic [BATTERY_BITS-1:0]       battery_caution_ff, battery_caution_in;
   logic signed [SIGNAL_BITS-1:0] signal_critical_ff, signal_critical_in;
   logic signed [SIGNAL_BITS-1:0] signal_caution_ff, signal_caution_in;
   logic signed [POS_BITS-1:0]    altitude_critical_ff, altitude_critical_in;
   logic signed [POS_BITS-1:0]    altitude_caution_ff, altitude_caution_in;
   logic signed [POS_BITS-1:0]    speed_critical_ff, speed_critical_in;
   logic signed [POS_BITS-1:0]    speed_caution_ff, speed_caution_in;

   logic                    battery_crit, battery_warn;
   logic                    signal_crit, signal_warn;
   logic                    altitude_crit, altitude_warn;
   logic                    speed_crit, speed_warn;
   logic [SCORE_BITS-1:0]   score_sum;
   logic [SCORE_BITS-1:0]   score;
   logic [LEVEL_BITS-1:0]   level;
   logic                    warning;

   // Register write decode; each register keeps only its own width.
   always_comb begin
      battery_critical_in  = battery_critical_ff;
      battery_caution_in   = battery_caution_ff;
      signal_critical_in   = signal_critical_ff;
      signal_caution_in    = signal_caution_ff;
      altitude_critical_in = altitude_critical_ff;
      altitude_caution_in  = altitude_caution_ff;
      speed_critical_in    = speed_critical_ff;
      speed_caution_in     = speed_caution_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_BATTERY_CRITICAL:  battery_critical_in  = csr_wdata[BATTERY_BITS-1:0];
            CSR_BATTERY_CAUTION:   battery_caution_in   = csr_wdata[BATTERY_BITS-1:0];
            CSR_SIGNAL_CRITICAL:   signal_critical_in   = csr_wdata[SIGNAL_BITS-1:0];
            CSR_SIGNAL_CAUTION:    signal_caution_in    = csr_wdata[SIGNAL_BITS-1:0];
            CSR_ALTITUDE_CRITICAL: altitude_critical_in = csr_wdata[POS_BITS-1:0];
            CSR_ALTITUDE_CAUTION:  altitude_caution_in  = csr_wdata[POS_BITS-1:0];
            CSR_SPEED_CRITICAL:    speed_critical_in    = csr_wdata[POS_BITS-1:0];
            CSR_SPEED_CAUTION:     speed_caution_in     = csr_wdata[POS_BITS-1:0];
         endcase
      end
   end

   // Threshold registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         battery_critical_ff  <= BATTERY_CRITICAL_RESET;
         battery_caution_ff   <= BATTERY_CAUTION_RESET;
         signal_critical_ff   <= SIGNAL_CRITICAL_RESET;
         signal_caution_ff    <= SIGNAL_CAUTION_RESET;
         altitude_critical_ff <= ALTITUDE_CRITICAL_RESET;
         altitude_caution_ff  <= ALTITUDE_CAUTION_RESET;
         speed_critical_ff    <= SPEED_CRITICAL_RESET;
         speed_caution_ff     <= SPEED_CAUTION_RESET;
      end else begin
         battery_critical_ff  <= battery_critical_in;
         battery_caution_ff   <= battery_caution_in;
         signal_critical_ff   <= signal_critical_in;
         signal_caution_ff    <= signal_caution_in;
         altitude_critical_ff <= altitude_critical_in;
         altitude_caution_ff  <= altitude_caution_in;
         speed_critical_ff    <= speed_critical_in;
         speed_caution_ff     <= speed_caution_in;
      end
   end

   // Threshold tests; the caution test counts only when the critical one misses.
   assign battery_crit  = req_battery < battery_critical_ff;
   assign battery_warn  = req_battery < battery_caution_ff;
   assign signal_crit   = req_signal_dbm < signal_critical_ff;
   assign signal_warn   = req_signal_dbm < signal_caution_ff;
   assign altitude_crit = req_altitude > altitude_critical_ff;
   assign altitude_warn = req_altitude > altitude_caution_ff;
   assign speed_crit    = req_velocity > speed_critical_ff;
   assign speed_warn    = req_velocity > speed_caution_ff;

   // Weight sum, saturation and level mapping. The sum never exceeds 115.
   always_comb begin
      score_sum = SCORE_NONE;
      if (battery_crit)       score_sum = score_sum + WEIGHT_BATTERY_CRITICAL;
      else if (battery_warn)  score_sum = score_sum + WEIGHT_BATTERY_CAUTION;
      if (signal_crit)        score_sum = score_sum + WEIGHT_SIGNAL_CRITICAL;
      else if (signal_warn)   score_sum = score_sum + WEIGHT_SIGNAL_CAUTION;
      if (altitude_crit)      score_sum = score_sum + WEIGHT_POS_CRITICAL;
      else if (altitude_warn) score_sum = score_sum + WEIGHT_POS_CAUTION;
      if (speed_crit)         score_sum = score_sum + WEIGHT_POS_CRITICAL;
      else if (speed_warn)    score_sum = score_sum + WEIGHT_POS_CAUTION;

      score = (score_sum > SCORE_MAX) ? SCORE_MAX : score_sum;

      if (score >= SCORE_CRITICAL)     level = LEVEL_CRITICAL;
      else if (score >= SCORE_HIGH)    level = LEVEL_HIGH;
      else if (score >= SCORE_WARNING) level = LEVEL_MEDIUM;
      else if (score != SCORE_NONE)    level = LEVEL_LOW;
      else                             level = LEVEL_NORMAL;

      warning = score >= SCORE_WARNING;
   end

   // Classified item handed to the queue.
   always_comb begin
      item.func        = trm_func_type'(req_func);
      item.altitude    = req_altitude;
      item.velocity    = req_velocity;
      item.battery     = req_battery;
      item.risk_score  = score;
      item.risk_level  = level;
      item.warning     = warning;
      item.alarm_flags = warning ? {speed_crit, altitude_crit, signal_crit, battery_crit}
                                 : '0;
   end

endmodule

// ----- hdl/trm_queue.sv -----
// Short queue of classified items between the front and the back end.
module trm_queue import trm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  trm_item_type  push_item,
   output logic          full,
   input  logic          pop,
   output trm_item_type  pop_item,
   output logic          empty
);

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

   trm_item_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_BITS:0]     fill_ff, fill_in;
   logic                  push_ok, pop_ok;

   assign full     = fill_ff == (PTR_BITS+1)'(QUEUE_DEPTH);
   assign empty    = fill_ff == '0;
   assign push_ok  = push & ~full;
   assign pop_ok   = pop & ~empty;
   assign pop_item = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push_ok ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_ok ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push_ok && !pop_ok)      fill_in = fill_ff + 1'b1;
      else if (!push_ok && pop_ok) fill_in = fill_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push_ok) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- hdl/trm_divider.sv -----
// Restoring divider, one quotient bit per cycle.
module trm_divider #(
   parameter int DIVIDEND_BITS = 64,
   parameter int DIVISOR_BITS  = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DIVIDEND_BITS-1:0] dividend,
   input  logic [DIVISOR_BITS-1:0]  divisor,
   output logic                     done,
   output logic [DIVIDEND_BITS-1:0] quotient
);

   localparam int STEP_BITS = $clog2(DIVIDEND_BITS);
   localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(DIVIDEND_BITS - 1);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [STEP_BITS-1:0]     step_ff, step_in;
   logic [DIVISOR_BITS-1:0]  rem_ff, rem_in;
   logic [DIVISOR_BITS-1:0]  divisor_ff, divisor_in;
   logic [DIVIDEND_BITS-1:0] quo_ff, quo_in;
   logic [DIVISOR_BITS:0]    trial;
   logic [DIVISOR_BITS:0]    diff;
   logic                     fits;

   // One restoring step: the dividend shifts out on top as quotient bits enter below.
   assign trial = {rem_ff, quo_ff[DIVIDEND_BITS-1]};
   assign diff  = trial - {1'b0, divisor_ff};
   assign fits  = trial >= {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      quo_in     = quo_ff;
      if (start) begin
         busy_in    = 1'b1;
         step_in    = '0;
         rem_in     = '0;
         divisor_in = divisor;
         quo_in     = dividend;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
         quo_in  = {quo_ff[DIVIDEND_BITS-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff    <= step_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      quo_ff     <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- hdl/trm_back.sv -----
// Back end: running statistics, average reports and the result register.
module trm_back import trm_pkg::*; #(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          queue_empty,
   input  trm_item_type                  queue_item,
   output logic                          queue_pop,
   input  logic                          rsp_pop,
   output logic                          rsp_empty,
   output logic [SCORE_BITS-1:0]         rsp_risk_score,
   output logic [LEVEL_BITS-1:0]         rsp_risk_level,
   output logic                          rsp_warning,
   output logic [FLAG_BITS-1:0]          rsp_alarm_flags,
   output logic [REPORT_BITS-1:0]        rsp_packet_count,
   output logic [REPORT_BITS-1:0]        rsp_warning_total,
   output logic signed [POS_BITS-1:0]    rsp_mean_altitude,
   output logic signed [POS_BITS-1:0]    rsp_mean_velocity,
   output logic [BATTERY_BITS-1:0]       rsp_mean_battery,
   output logic signed [POS_BITS-1:0]    rsp_peak_altitude,
   output logic signed [POS_BITS-1:0]    rsp_peak_velocity,
   output logic [BATTERY_BITS-1:0]       rsp_lowest_battery
);

   localparam int EXT_BITS = SUM_BITS - POS_BITS;

   trm_back_state_type           state_ff, state_in;

   // Statistics.
   logic [COUNT_BITS-1:0]        count_ff, count_in;
   logic [COUNT_BITS-1:0]        warn_count_ff, warn_count_in;
   logic [SUM_BITS-1:0]          altitude_sum_ff, altitude_sum_in;
   logic [SUM_BITS-1:0]          velocity_sum_ff, velocity_sum_in;
   logic [SUM_BITS-1:0]          battery_sum_ff, battery_sum_in;
   logic signed [POS_BITS-1:0]   altitude_peak_ff, altitude_peak_in;
   logic signed [POS_BITS-1:0]   velocity_peak_ff, velocity_peak_in;
   logic [BATTERY_BITS-1:0]      battery_floor_ff, battery_floor_in;

   // Result register.
   logic                         out_valid_ff, out_valid_in;
   logic [SCORE_BITS-1:0]        score_ff, score_in;
   logic [LEVEL_BITS-1:0]        level_ff, level_in;
   logic                         warning_ff, warning_in;
   logic [FLAG_BITS-1:0]         flags_ff, flags_in;
   logic [REPORT_BITS-1:0]       packets_ff, packets_in;
   logic [REPORT_BITS-1:0]       warnings_ff, warnings_in;
   logic [POS_BITS-1:0]          mean_alt_ff, mean_alt_in;
   logic [POS_BITS-1:0]          mean_vel_ff, mean_vel_in;
   logic [BATTERY_BITS-1:0]      mean_bat_ff, mean_bat_in;
   logic [POS_BITS-1:0]          peak_alt_ff, peak_alt_in;
   logic [POS_BITS-1:0]          peak_vel_ff, peak_vel_in;
   logic [BATTERY_BITS-1:0]      low_bat_ff, low_bat_in;

   // Division lanes.
   logic                         div_start;
   logic                         alt_done, vel_done, bat_done, div_done;
   logic                         alt_neg, vel_neg;
   logic [SUM_BITS-1:0]          alt_mag, vel_mag;
   logic [SUM_BITS-1:0]          alt_quo, vel_quo, bat_quo;

   logic                         load_out;
   logic [SCORE_BITS-1:0]        sel_score;
   logic [LEVEL_BITS-1:0]        sel_level;
   logic                         sel_warning;
   logic [FLAG_BITS-1:0]         sel_flags;
   logic [POS_BITS-1:0]          sel_mean_alt, sel_mean_vel;
   logic [BATTERY_BITS-1:0]      sel_mean_bat;

   // Signed mean limits: magnitude clipped at 2^23, then positive side at 2^23-1.
   function automatic logic [POS_BITS-1:0] clip_signed_mean(
      input logic neg, input logic [SUM_BITS-1:0] q);
      logic [POS_BITS-1:0] res;
      if (neg) begin
         if (q >= SUM_BITS'(64'd8388608)) res = 24'h800000;
         else                             res = POS_BITS'(~q[POS_BITS-1:0] + 1'b1);
      end else begin
         if (q > SUM_BITS'(64'd8388607))  res = 24'h7FFFFF;
         else                             res = q[POS_BITS-1:0];
      end
      return res;
   endfunction

   // Sums are divided as magnitudes; the sign is applied afterwards.
   assign alt_neg  = altitude_sum_ff[SUM_BITS-1];
   assign vel_neg  = velocity_sum_ff[SUM_BITS-1];
   assign alt_mag  = alt_neg ? (~altitude_sum_ff + 1'b1) : altitude_sum_ff;
   assign vel_mag  = vel_neg ? (~velocity_sum_ff + 1'b1) : velocity_sum_ff;
   assign div_done = alt_done & vel_done & bat_done;

   trm_divider #(.DIVIDEND_BITS(SUM_BITS), .DIVISOR_BITS(COUNT_BITS)) u_div_altitude (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (alt_mag),
      .divisor  (count_ff),
      .done     (alt_done),
      .quotient (alt_quo)
   );

   trm_divider #(.DIVIDEND_BITS(SUM_BITS), .DIVISOR_BITS(COUNT_BITS)) u_div_velocity (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (vel_mag),
      .divisor  (count_ff),
      .done     (vel_done),
      .quotient (vel_quo)
   );

   trm_divider #(.DIVIDEND_BITS(SUM_BITS), .DIVISOR_BITS(COUNT_BITS)) u_div_battery (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (battery_sum_ff),
      .divisor  (count_ff),
      .done     (bat_done),
      .quotient (bat_quo)
   );

   // Sequencer: pop an item, update statistics or start the mean divisions, load the result.
   always_comb begin
      state_in         = state_ff;
      count_in         = count_ff;
      warn_count_in    = warn_count_ff;
      altitude_sum_in  = altitude_sum_ff;
      velocity_sum_in  = velocity_sum_ff;
      battery_sum_in   = battery_sum_ff;
      altitude_peak_in = altitude_peak_ff;
      velocity_peak_in = velocity_peak_ff;
      battery_floor_in = battery_floor_ff;
      queue_pop        = 1'b0;
      div_start        = 1'b0;
      load_out         = 1'b0;
      sel_score        = SCORE_NONE;
      sel_level        = LEVEL_NORMAL;
      sel_warning      = 1'b0;
      sel_flags        = '0;
      sel_mean_alt     = '0;
      sel_mean_vel     = '0;
      sel_mean_bat     = '0;

      unique case (state_ff)
         BACK_RUN: begin
            if (!queue_empty && (!out_valid_ff || rsp_pop)) begin
               queue_pop = 1'b1;
               unique case (queue_item.func)
                  FUNC_SAMPLE: begin
                     load_out        = 1'b1;
                     sel_score       = queue_item.risk_score;
                     sel_level       = queue_item.risk_level;
                     sel_warning     = queue_item.warning;
                     sel_flags       = queue_item.alarm_flags;
                     count_in        = count_ff + COUNT_BITS'(1);
                     if (queue_item.warning) begin
                        warn_count_in = warn_count_ff + COUNT_BITS'(1);
                     end
                     altitude_sum_in = altitude_sum_ff +
                        {{EXT_BITS{queue_item.altitude[POS_BITS-1]}}, queue_item.altitude};
                     velocity_sum_in = velocity_sum_ff +
                        {{EXT_BITS{queue_item.velocity[POS_BITS-1]}}, queue_item.velocity};
                     battery_sum_in  = battery_sum_ff +
                        {{(SUM_BITS-BATTERY_BITS){1'b0}}, queue_item.battery};
                     if ($signed(queue_item.altitude) > $signed(altitude_peak_ff)) begin
                        altitude_peak_in = queue_item.altitude;
                     end
                     if ($signed(queue_item.velocity) > $signed(velocity_peak_ff)) begin
                        velocity_peak_in = queue_item.velocity;
                     end
                     if (queue_item.battery < battery_floor_ff) begin
                        battery_floor_in = queue_item.battery;
                     end
                  end
                  FUNC_REPORT: begin
                     if (count_ff == '0) begin
                        load_out = 1'b1;
                     end else begin
                        div_start = 1'b1;
                        state_in  = BACK_DIVIDE;
                     end
                  end
                  FUNC_CLEAR: begin
                     load_out         = 1'b1;
                     count_in         = '0;
                     warn_count_in    = '0;
                     altitude_sum_in  = '0;
                     velocity_sum_in  = '0;
                     battery_sum_in   = '0;
                     altitude_peak_in = '0;
                     velocity_peak_in = '0;
                     battery_floor_in = BATTERY_FULL;
                  end
                  FUNC_UNUSED: begin
                     load_out = 1'b1;
                  end
               endcase
            end
         end
         BACK_DIVIDE: begin
            if (div_done) begin
               load_out     = 1'b1;
               state_in     = BACK_RUN;
               sel_mean_alt = clip_signed_mean(alt_neg, alt_quo);
               sel_mean_vel = clip_signed_mean(vel_neg, vel_quo);
               sel_mean_bat = (bat_quo > SUM_BITS'(64'd32767)) ? '1
                                                               : bat_quo[BATTERY_BITS-1:0];
            end
         end
      endcase
   end

   // Result register load; a result leaves when it is popped.
   always_comb begin
      out_valid_in = out_valid_ff & ~rsp_pop;
      score_in     = score_ff;
      level_in     = level_ff;
      warning_in   = warning_ff;
      flags_in     = flags_ff;
      packets_in   = packets_ff;
      warnings_in  = warnings_ff;
      mean_alt_in  = mean_alt_ff;
      mean_vel_in  = mean_vel_ff;
      mean_bat_in  = mean_bat_ff;
      peak_alt_in  = peak_alt_ff;
      peak_vel_in  = peak_vel_ff;
      low_bat_in   = low_bat_ff;
      if (load_out) begin
         out_valid_in = 1'b1;
         score_in     = sel_score;
         level_in     = sel_level;
         warning_in   = sel_warning;
         flags_in     = sel_flags;
         packets_in   = REPORT_BITS'(count_in);
         warnings_in  = REPORT_BITS'(warn_count_in);
         mean_alt_in  = sel_mean_alt;
         mean_vel_in  = sel_mean_vel;
         mean_bat_in  = sel_mean_bat;
         peak_alt_in  = altitude_peak_in;
         peak_vel_in  = velocity_peak_in;
         low_bat_in   = battery_floor_in;
      end
   end

   // Control and statistics registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= BACK_RUN;
         out_valid_ff     <= 1'b0;
         count_ff         <= '0;
         warn_count_ff    <= '0;
         altitude_sum_ff  <= '0;
         velocity_sum_ff  <= '0;
         battery_sum_ff   <= '0;
         altitude_peak_ff <= '0;
         velocity_peak_ff <= '0;
         battery_floor_ff <= BATTERY_FULL;
      end else begin
         state_ff         <= state_in;
         out_valid_ff     <= out_valid_in;
         count_ff         <= count_in;
         warn_count_ff    <= warn_count_in;
         altitude_sum_ff  <= altitude_sum_in;
         velocity_sum_ff  <= velocity_sum_in;
         battery_sum_ff   <= battery_sum_in;
         altitude_peak_ff <= altitude_peak_in;
         velocity_peak_ff <= velocity_peak_in;
         battery_floor_ff <= battery_floor_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      score_ff    <= score_in;
      level_ff    <= level_in;
      warning_ff  <= warning_in;
      flags_ff    <= flags_in;
      packets_ff  <= packets_in;
      warnings_ff <= warnings_in;
      mean_alt_ff <= mean_alt_in;
      mean_vel_ff <= mean_vel_in;
      mean_bat_ff <= mean_bat_in;
      peak_alt_ff <= peak_alt_in;
      peak_vel_ff <= peak_vel_in;
      low_bat_ff  <= low_bat_in;
   end

   assign rsp_empty          = ~out_valid_ff;
   assign rsp_risk_score     = score_ff;
   assign rsp_risk_level     = level_ff;
   assign rsp_warning        = warning_ff;
   assign rsp_alarm_flags    = flags_ff;
   assign rsp_packet_count   = packets_ff;
   assign rsp_warning_total  = warnings_ff;
   assign rsp_mean_altitude  = mean_alt_ff;
   assign rsp_mean_velocity  = mean_vel_ff;
   assign rsp_mean_battery   = mean_bat_ff;
   assign rsp_peak_altitude  = peak_alt_ff;
   assign rsp_peak_velocity  = peak_vel_ff;
   assign rsp_lowest_battery = low_bat_ff;

endmodule

// ----- hdl/telemetry_risk_monitor.sv -----
// Top level of the telemetry risk monitor: front end, item queue and back end.
//
//   Channel   Direction  Handshake               Contents
//   req_*     in         push / full             function code and one telemetry sample
//   rsp_*     out        pop / empty             score, level, alarms and statistics
//   csr_*     in         write, no wait          eight threshold registers
//
// Sample and clear items stay in the run state and follow back to back as results pop.
// A report with a nonzero count waits in the divide state for the bit-serial dividers.
// With nothing queued ahead, an item passes a queue entry and then the result register.
// Until full, the four-entry queue takes items as the back end divides or a result waits.
// Reset is synchronous and restores thresholds and statistics.
module telemetry_risk_monitor import trm_pkg::*; #(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_wdata,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [1:0]                    req_func,
   input  logic signed [POS_BITS-1:0]    req_altitude,
   input  logic signed [POS_BITS-1:0]    req_velocity,
   input  logic [BATTERY_BITS-1:0]       req_battery,
   input  logic signed [SIGNAL_BITS-1:0] req_signal_dbm,
   input  logic                          rsp_pop,
   output logic                          rsp_empty,
   output logic [SCORE_BITS-1:0]         rsp_risk_score,
   output logic [LEVEL_BITS-1:0]         rsp_risk_level,
   output logic                          rsp_warning,
   output logic [FLAG_BITS-1:0]          rsp_alarm_flags,
   output logic [REPORT_BITS-1:0]        rsp_packet_count,
   output logic [REPORT_BITS-1:0]        rsp_warning_total,
   output logic signed [POS_BITS-1:0]    rsp_mean_altitude,
   output logic signed [POS_BITS-1:0]    rsp_mean_velocity,
   output logic [BATTERY_BITS-1:0]       rsp_mean_battery,
   output logic signed [POS_BITS-1:0]    rsp_peak_altitude,
   output logic signed [POS_BITS-1:0]    rsp_peak_velocity,
   output logic [BATTERY_BITS-1:0]       rsp_lowest_battery
);

   trm_item_type front_item;
   trm_item_type queue_item;
   logic         queue_empty;
   logic         queue_pop;

   // Scoring of incoming items.
   trm_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_func       (req_func),
      .req_altitude   (req_altitude),
      .req_velocity   (req_velocity),
      .req_battery    (req_battery),
      .req_signal_dbm (req_signal_dbm),
      .item           (front_item)
   );

   // Decoupling queue.
   trm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_item (front_item),
      .full      (req_full),
      .pop       (queue_pop),
      .pop_item  (queue_item),
      .empty     (queue_empty)
   );

   // Statistics and results.
   trm_back #(.COUNT_BITS(COUNT_BITS)) u_back (
      .clock              (clock),
      .reset              (reset),
      .queue_empty        (queue_empty),
      .queue_item         (queue_item),
      .queue_pop          (queue_pop),
      .rsp_pop            (rsp_pop),
      .rsp_empty          (rsp_empty),
      .rsp_risk_score     (rsp_risk_score),
      .rsp_risk_level     (rsp_risk_level),
      .rsp_warning        (rsp_warning),
      .rsp_alarm_flags    (rsp_alarm_flags),
      .rsp_packet_count   (rsp_packet_count),
      .rsp_warning_total  (rsp_warning_total),
      .rsp_mean_altitude  (rsp_mean_altitude),
      .rsp_mean_velocity  (rsp_mean_velocity),
      .rsp_mean_battery   (rsp_mean_battery),
      .rsp_peak_altitude  (rsp_peak_altitude),
      .rsp_peak_velocity  (rsp_peak_velocity),
      .rsp_lowest_battery (rsp_lowest_battery)
   );

endmodule

// ----- hdl/trm_checker.sv -----
// Port-level checker of the risk monitor and its bind to the top level.
`include "assert_macros.svh"

module trm_checker import trm_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_pop,
   input logic                    rsp_empty,
   input logic [SCORE_BITS-1:0]   rsp_risk_score,
   input logic [LEVEL_BITS-1:0]   rsp_risk_level,
   input logic                    rsp_warning,
   input logic [FLAG_BITS-1:0]    rsp_alarm_flags,
   input logic [REPORT_BITS-1:0]  rsp_packet_count,
   input logic [POS_BITS-1:0]     rsp_mean_altitude
);

   // Reset leaves no result behind.
   `TRM_ASSERT_RESET(a_reset_empty, clock, reset, rsp_empty)

   // A waiting result stays put until it is popped.
   `TRM_ASSERT_NEXT(a_result_held, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_risk_score) && $stable(rsp_packet_count) && $stable(rsp_mean_altitude))

   // The warning bit follows the score threshold.
   `TRM_ASSERT_IMP(a_warning_score, clock, reset, !rsp_empty, rsp_warning == (rsp_risk_score >= SCORE_WARNING))

   // Alarm flags show only on a warning.
   `TRM_ASSERT_IMP(a_flags_warning, clock, reset, !rsp_empty && !rsp_warning, rsp_alarm_flags == '0)

   // Level is normal exactly when the score is zero.
   `TRM_ASSERT_IMP(a_level_score, clock, reset, !rsp_empty, (rsp_risk_score == SCORE_NONE) == (rsp_risk_level == LEVEL_NORMAL))

endmodule

bind telemetry_risk_monitor trm_checker u_checker (.*);
